// ===== rtl/ils_pkg.sv =====
// shared types, widths and codes for the indexed list store
package ils_pkg;

  // default list capacity
  localparam int DEPTH_DEF = 256;

  // fixed field widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP     = 3'd3;
  localparam logic [OP_W-1:0] OP_GET     = 3'd4;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd5;
  localparam logic [OP_W-1:0] OP_TRUNC   = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP     = 3'd7;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_INS_WR,
    S_FIN
  } state_t;

endpackage

// ===== rtl/ils_ram.sv =====
// generic single write port, single read port ram with registered read
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ils_ctrl.sv =====
// request sequencer: decode, read-modify-write and shift passes over the list ram
module ils_ctrl #(
  parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ils_pkg::OP_W-1:0]      in_opcode,
  input  logic [ils_pkg::POS_W-1:0]     in_position,
  input  logic [ils_pkg::DATA_W-1:0]    in_value,
  input  logic                          in_shrink,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ils_pkg::DATA_W-1:0]    out_data,
  output logic [ils_pkg::STAT_W-1:0]    out_status,
  output logic [ils_pkg::POS_W-1:0]     out_count,
  // ram port
  output logic                          mem_we,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr,
  output logic [ils_pkg::DATA_W-1:0]    mem_wdata,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr,
  input  logic [ils_pkg::DATA_W-1:0]    mem_rdata
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;

  ils_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]             ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]             lim_r, lim_nxt;
  logic [ils_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [ils_pkg::DATA_W-1:0]    val_r, val_nxt;
  logic [ils_pkg::DATA_W-1:0]    data_r, data_nxt;
  logic [ils_pkg::STAT_W-1:0]    stat_r, stat_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ils_pkg::DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [ils_pkg::STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [ils_pkg::POS_W-1:0]     out_count_r, out_count_nxt;

  // request decode
  logic [ils_pkg::OP_W-1:0] op_eff;
  logic [CMP_W-1:0]         pos_x;
  logic [CMP_W-1:0]         cnt_x;
  logic [CNT_W-1:0]         cnt_m1;
  logic [ADDR_W-1:0]        cnt_a;
  logic [ADDR_W-1:0]        cnt_m1_a;
  logic [ADDR_W-1:0]        pos_a;
  logic                     pos_ge;
  logic                     pos_gt;
  logic                     full;
  logic                     empty;
  logic                     in_fire;
  logic                     out_free;
  logic                     at_lim;
  logic                     is_rem;

  assign op_eff   = in_shrink ? ils_pkg::OP_TRUNC : in_opcode;
  assign pos_x    = CMP_W'(in_position);
  assign cnt_x    = CMP_W'(cnt_r);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_a    = cnt_r[ADDR_W-1:0];
  assign cnt_m1_a = cnt_m1[ADDR_W-1:0];
  assign pos_a    = pos_x[ADDR_W-1:0];
  assign pos_ge   = pos_x >= cnt_x;
  assign pos_gt   = pos_x > cnt_x;
  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign in_fire  = in_valid && (state_r == ils_pkg::S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign at_lim   = ptr_r == lim_r;
  assign is_rem   = (op_r == ils_pkg::OP_REMOVE) || (op_r == ils_pkg::OP_POP);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ils_pkg::S_IDLE: begin
        if (in_fire) begin
          case (op_eff)
            ils_pkg::OP_INSERT: begin
              state_nxt = (!pos_ge && !full) ? ils_pkg::S_SHIFT_UP : ils_pkg::S_FIN;
            end
            ils_pkg::OP_REMOVE, ils_pkg::OP_GET, ils_pkg::OP_REPLACE: begin
              state_nxt = pos_ge ? ils_pkg::S_FIN : ils_pkg::S_READ;
            end
            ils_pkg::OP_POP: begin
              state_nxt = empty ? ils_pkg::S_FIN : ils_pkg::S_READ;
            end
            default: begin
              state_nxt = ils_pkg::S_FIN;
            end
          endcase
        end
      end
      ils_pkg::S_READ: begin
        state_nxt = (is_rem && !at_lim) ? ils_pkg::S_SHIFT_DN : ils_pkg::S_FIN;
      end
      ils_pkg::S_SHIFT_DN: begin
        state_nxt = at_lim ? ils_pkg::S_FIN : ils_pkg::S_SHIFT_DN;
      end
      ils_pkg::S_SHIFT_UP: begin
        state_nxt = at_lim ? ils_pkg::S_INS_WR : ils_pkg::S_SHIFT_UP;
      end
      ils_pkg::S_INS_WR: begin
        state_nxt = ils_pkg::S_FIN;
      end
      ils_pkg::S_FIN: begin
        state_nxt = out_free ? ils_pkg::S_IDLE : ils_pkg::S_FIN;
      end
      default: begin
        state_nxt = ils_pkg::S_IDLE;
      end
    endcase
  end

  // datapath, ram control and result register
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = ptr_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    lim_nxt        = lim_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    data_nxt       = data_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    in_ready       = state_r == ils_pkg::S_IDLE;
    case (state_r)
      ils_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt   = op_eff;
          val_nxt  = in_value;
          data_nxt = '0;
          stat_nxt = ils_pkg::ST_OK;
          case (op_eff)
            ils_pkg::OP_APPEND: begin
              if (full) begin
                stat_nxt = ils_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_a;
                mem_wdata = in_value;
                cnt_nxt   = cnt_r + CNT_W'(1);
                data_nxt  = in_value;
              end
            end
            ils_pkg::OP_INSERT: begin
              if (pos_gt) begin
                stat_nxt = ils_pkg::ST_RANGE;
              end else if (full) begin
                stat_nxt = ils_pkg::ST_FULL;
              end else if (!pos_ge) begin
                // shift pass from the tail down to the position
                mem_raddr = cnt_m1_a;
                ptr_nxt   = cnt_m1_a;
                lim_nxt   = pos_a;
              end else begin
                // insert at the tail is an append
                mem_we    = 1'b1;
                mem_waddr = cnt_a;
                mem_wdata = in_value;
                cnt_nxt   = cnt_r + CNT_W'(1);
                data_nxt  = in_value;
              end
            end
            ils_pkg::OP_REMOVE, ils_pkg::OP_GET, ils_pkg::OP_REPLACE: begin
              if (pos_ge) begin
                stat_nxt = ils_pkg::ST_RANGE;
              end else begin
                mem_raddr = pos_a;
                ptr_nxt   = pos_a;
                lim_nxt   = cnt_m1_a;
              end
            end
            ils_pkg::OP_POP: begin
              if (empty) begin
                stat_nxt = ils_pkg::ST_EMPTY;
              end else begin
                mem_raddr = cnt_m1_a;
                ptr_nxt   = cnt_m1_a;
                lim_nxt   = cnt_m1_a;
              end
            end
            ils_pkg::OP_TRUNC: begin
              if (!pos_ge) begin
                cnt_nxt = pos_x[CNT_W-1:0];
              end
            end
            default: begin
              stat_nxt = ils_pkg::ST_OK;
            end
          endcase
        end
      end
      ils_pkg::S_READ: begin
        data_nxt = mem_rdata;
        if (op_r == ils_pkg::OP_REPLACE) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_r;
          mem_wdata = val_r;
        end else if (is_rem) begin
          if (at_lim) begin
            cnt_nxt = cnt_m1;
          end else begin
            mem_raddr = ptr_r + ADDR_W'(1);
            ptr_nxt   = ptr_r + ADDR_W'(1);
          end
        end
      end
      ils_pkg::S_SHIFT_DN: begin
        // move the word read last cycle one place toward the head
        mem_we    = 1'b1;
        mem_waddr = ptr_r - ADDR_W'(1);
        mem_wdata = mem_rdata;
        if (at_lim) begin
          cnt_nxt = cnt_m1;
        end else begin
          mem_raddr = ptr_r + ADDR_W'(1);
          ptr_nxt   = ptr_r + ADDR_W'(1);
        end
      end
      ils_pkg::S_SHIFT_UP: begin
        // move the word read last cycle one place toward the tail
        mem_we    = 1'b1;
        mem_waddr = ptr_r + ADDR_W'(1);
        mem_wdata = mem_rdata;
        if (!at_lim) begin
          mem_raddr = ptr_r - ADDR_W'(1);
          ptr_nxt   = ptr_r - ADDR_W'(1);
        end
      end
      ils_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        data_nxt  = val_r;
      end
      ils_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = data_r;
          out_status_nxt = stat_r;
          out_count_nxt  = cnt_x[ils_pkg::POS_W-1:0];
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ils_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    lim_r        <= lim_nxt;
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    data_r       <= data_nxt;
    stat_r       <= stat_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

// ===== rtl/indexed_list_store_top.sv =====
// Ordered list of up to DEPTH words held in one ram with a registered read.
// Insert and remove shift entries in a pass that moves one entry per cycle through the ram ports.
// Throughput: one transaction in flight; the next is taken once the result is registered.
// Reset clears the count and the handshake state; list storage is left undefined.
module indexed_list_store_top #(
  parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ils_pkg::OP_W-1:0]      in_opcode,
  input  logic [ils_pkg::POS_W-1:0]     in_position,
  input  logic [ils_pkg::DATA_W-1:0]    in_value,
  input  logic                          in_shrink,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ils_pkg::DATA_W-1:0]    out_data,
  output logic [ils_pkg::STAT_W-1:0]    out_status,
  output logic [ils_pkg::POS_W-1:0]     out_count
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [ils_pkg::DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [ils_pkg::DATA_W-1:0] mem_rdata;

  // request sequencer
  ils_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_position (in_position),
    .in_value    (in_value),
    .in_shrink   (in_shrink),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .out_status  (out_status),
    .out_count   (out_count),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // list storage
  ils_ram #(
    .WIDTH (ils_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule
